/* rtl/core/cnd_pkg.sv */
// ----------------------------------------------------------------------------
// cnd_pkg
// Types, codes and lookup functions shared by the cpio newc entry deframer.
// ----------------------------------------------------------------------------
package cnd_pkg;

    localparam int POS_W = 32;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_NAME   = 2'd1;
    localparam logic [1:0] PH_SKIP   = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    localparam logic [6:0] HDR_LAST   = 7'd109;
    localparam logic [6:0] MAGIC_LEN  = 7'd6;
    localparam logic [6:0] MODE_FIRST = 7'd14;
    localparam logic [6:0] MODE_LAST  = 7'd21;
    localparam logic [6:0] SIZE_FIRST = 7'd54;
    localparam logic [6:0] SIZE_LAST  = 7'd61;
    localparam logic [6:0] NLEN_FIRST = 7'd94;
    localparam logic [6:0] NLEN_LAST  = 7'd101;

    localparam logic [3:0] NAME_IDX_MAX = 4'd13;
    localparam logic [3:0] TRAILER_LEN  = 4'd10;

    localparam logic [2:0] KIND_DIR       = 3'd0;
    localparam logic [2:0] KIND_FILE      = 3'd1;
    localparam logic [2:0] KIND_IGNORED   = 3'd2;
    localparam logic [2:0] KIND_TRAILER   = 3'd3;
    localparam logic [2:0] KIND_FIRST_BAD = 3'd4;
    localparam logic [2:0] KIND_LATER_BAD = 3'd5;

    localparam logic [3:0] TYPE_DIR  = 4'd4;
    localparam logic [3:0] TYPE_REG  = 4'd8;
    localparam logic [3:0] TYPE_LINK = 4'd10;

    localparam logic CFG_STRIP_DOT   = 1'b0;
    localparam logic CFG_STRIP_SLASH = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       archive_start;
    } t_beat;

    typedef struct packed {
        logic [2:0]       record_kind;
        logic [3:0]       file_type;
        logic [POS_W-1:0] file_size;
        logic [POS_W-1:0] data_offset;
        logic [POS_W-1:0] name_offset;
        logic [POS_W-1:0] name_size;
        logic [POS_W-1:0] file_count;
    } t_record;

    typedef struct packed {
        logic strip_dot;
        logic strip_slash;
    } t_cfg;

    typedef struct packed {
        logic [1:0] phase;
        logic [6:0] hdr_idx;
    } t_status;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
        end else if (c inside {[8'h41:8'h46]}) begin
            d = c - 8'h37;
        end else if (c inside {[8'h61:8'h66]}) begin
            d = c - 8'h57;
        end
        return d[3:0];
    endfunction

    function automatic logic [7:0] magic_char(input logic [2:0] k);
        logic [7:0] c;
        case (k)
            3'd0, 3'd2, 3'd4: c = "0";
            3'd1, 3'd3: c = "7";
            3'd5: c = "1";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] trailer_char(input logic [3:0] k);
        logic [7:0] c;
        case (k)
            4'd0: c = "T";
            4'd1: c = "R";
            4'd2: c = "A";
            4'd3: c = "I";
            4'd4: c = "L";
            4'd5: c = "E";
            4'd6: c = "R";
            4'd7, 4'd8, 4'd9: c = "!";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/cnd_byte_if.sv */
// ----------------------------------------------------------------------------
// cnd_byte_if
// Archive byte channel: one archive byte and the restart flag per beat.
// ----------------------------------------------------------------------------
interface cnd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       archive_start;

    modport source (output valid, output data_byte, output archive_start, input ready);
    modport sink (input valid, input data_byte, input archive_start, output ready);
endinterface

/* rtl/core/cnd_rec_if.sv */
// ----------------------------------------------------------------------------
// cnd_rec_if
// Entry record channel: one decoded entry description per beat.
// ----------------------------------------------------------------------------
interface cnd_rec_if;
    logic        valid;
    logic        ready;
    logic [2:0]  record_kind;
    logic [3:0]  file_type;
    logic [31:0] file_size;
    logic [31:0] data_offset;
    logic [31:0] name_offset;
    logic [31:0] name_size;
    logic [31:0] file_count;

    modport source (
        output valid, output record_kind, output file_type, output file_size,
        output data_offset, output name_offset, output name_size, output file_count,
        input ready
    );
    modport sink (
        input valid, input record_kind, input file_type, input file_size,
        input data_offset, input name_offset, input name_size, input file_count,
        output ready
    );
endinterface

/* rtl/core/cnd_in_stage.sv */
// ----------------------------------------------------------------------------
// cnd_in_stage
// Input register for archive bytes; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module cnd_in_stage
    import cnd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    cnd_byte_if.sink    i_byte,
    input  logic        i_adv,
    output logic        o_valid,
    output t_beat       o_beat
);

    logic  r_valid;
    t_beat r_beat;

    assign i_byte.ready = !r_valid || i_adv;
    assign o_valid      = r_valid;
    assign o_beat       = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_beat.data_byte     <= i_byte.data_byte;
            r_beat.archive_start <= i_byte.archive_start;
        end
    end

endmodule

/* rtl/core/cnd_parser.sv */
// ----------------------------------------------------------------------------
// cnd_parser
// Header, name and skip tracking, one archive byte per cycle while i_adv is
// high; a record is built at an entry's last byte or at a bad magic byte.
// ----------------------------------------------------------------------------
module cnd_parser
    import cnd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_beat   i_beat,
    input  t_cfg    i_cfg,
    output logic    o_produce,
    output t_record o_rec,
    output t_status o_status
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_pos_p1, n_pos_p1;
    logic [1:0]       r_phase, n_phase;
    logic [6:0]       r_hdr, n_hdr;
    logic [15:0]      r_mode, n_mode;
    logic [POS_W-1:0] r_size, n_size;
    logic [POS_W-1:0] r_size_al;
    logic [POS_W-1:0] r_nlen, n_nlen;
    logic [POS_W-1:0] r_left, n_left;
    logic [23:0]      r_prefix, n_prefix;
    logic [3:0]       r_tmatch, n_tmatch;
    logic [3:0]       r_name_idx, n_name_idx;
    logic [POS_W-1:0] r_name_start, n_name_start;
    logic [POS_W-1:0] r_files, n_files;
    logic             r_first, n_first;

    logic [POS_W-1:0] pos_cur, pos1_cur, files_cur, files_inc;
    logic [1:0]       phase_cur;
    logic [6:0]       hdr_cur;
    logic             first_cur;
    logic [7:0]       b;
    logic [3:0]       hexv;

    logic [23:0]      upd_prefix, fin_prefix;
    logic [3:0]       upd_tmatch, fin_tmatch;
    logic [7:0]       p0, p1, ps;
    logic             dot, slash, trailer, is_reg;
    logic [1:0]       s0, s;
    logic [3:0]       ty;
    logic [POS_W-1:0] data_off, skip_len, name_base, name_off;
    logic [2:0]       fin_kind;
    logic             do_finish;

    assign b         = i_beat.data_byte;
    assign hexv      = hex_value(b);
    assign pos_cur   = i_beat.archive_start ? '0 : r_pos;
    assign pos1_cur  = i_beat.archive_start ? POS_W'(1) : r_pos_p1;
    assign phase_cur = i_beat.archive_start ? PH_HEADER : r_phase;
    assign hdr_cur   = i_beat.archive_start ? 7'd0 : r_hdr;
    assign files_cur = i_beat.archive_start ? '0 : r_files;
    assign first_cur = i_beat.archive_start ? 1'b1 : r_first;
    assign files_inc = (files_cur != '1) ? files_cur + POS_W'(1) : files_cur;

    always_comb begin
        logic [3:0] k;
        upd_prefix = r_prefix;
        upd_tmatch = r_tmatch;
        k          = 4'd0;
        if (r_name_idx < 4'd3) begin
            upd_prefix[8*r_name_idx[1:0] +: 8] = b;
        end
        for (int j = 0; j < 4; j++) begin
            k = r_name_idx - 4'(j);
            if (r_name_idx >= 4'(j) && k < TRAILER_LEN && b != trailer_char(k)) begin
                upd_tmatch[j] = 1'b0;
            end
        end
    end

    assign fin_prefix = (phase_cur == PH_NAME) ? upd_prefix : 24'd0;
    assign fin_tmatch = (phase_cur == PH_NAME) ? upd_tmatch : 4'hF;
    assign p0 = fin_prefix[7:0];
    assign p1 = fin_prefix[15:8];

    assign dot     = i_cfg.strip_dot && (r_nlen >= POS_W'(2)) && p0 == "." && p1 == "/";
    assign s0      = dot ? 2'd2 : 2'd0;
    assign ps      = dot ? fin_prefix[23:16] : p0;
    assign slash   = i_cfg.strip_slash && (r_nlen > {30'd0, s0}) && ps == "/";
    assign s       = s0 + {1'b0, slash};
    assign trailer = fin_tmatch[s] && (r_nlen >= {30'd0, s} + POS_W'(10));

    assign ty        = r_mode[15:12];
    assign is_reg    = (ty == TYPE_REG) || (ty == TYPE_LINK);
    assign data_off  = {pos_cur[POS_W-1:2] + 30'd1, 2'b00};
    assign skip_len  = r_size_al + {30'd0, 2'd3 - pos_cur[1:0]};
    assign name_base = (phase_cur == PH_NAME) ? r_name_start : pos1_cur;
    assign name_off  = name_base + {30'd0, s};

    always_comb begin
        if (trailer) begin
            fin_kind = KIND_TRAILER;
        end else if (ty == TYPE_DIR || (is_reg && r_size == '0)) begin
            fin_kind = KIND_DIR;
        end else if (is_reg) begin
            fin_kind = KIND_FILE;
        end else begin
            fin_kind = KIND_IGNORED;
        end
    end

    always_comb begin
        n_pos        = r_pos;
        n_pos_p1     = r_pos_p1;
        n_phase      = r_phase;
        n_hdr        = r_hdr;
        n_mode       = r_mode;
        n_size       = r_size;
        n_nlen       = r_nlen;
        n_left       = r_left;
        n_prefix     = r_prefix;
        n_tmatch     = r_tmatch;
        n_name_idx   = r_name_idx;
        n_name_start = r_name_start;
        n_files      = r_files;
        n_first      = r_first;
        do_finish    = 1'b0;
        o_produce    = 1'b0;
        o_rec        = '0;
        if (i_adv) begin
            n_pos    = pos1_cur;
            n_pos_p1 = pos1_cur + POS_W'(1);
            n_phase  = phase_cur;
            n_hdr    = hdr_cur;
            n_files  = files_cur;
            n_first  = first_cur;
            case (phase_cur)
                PH_HEADER: begin
                    if (hdr_cur == 7'd0) begin
                        n_mode = '0;
                        n_size = '0;
                        n_nlen = '0;
                    end
                    if (hdr_cur < MAGIC_LEN && b != magic_char(hdr_cur[2:0])) begin
                        o_produce          = 1'b1;
                        o_rec.record_kind  = first_cur ? KIND_FIRST_BAD : KIND_LATER_BAD;
                        o_rec.file_count   = files_cur;
                        n_hdr              = 7'd0;
                        n_phase            = PH_DONE;
                    end else begin
                        if (hdr_cur inside {[MODE_FIRST:MODE_LAST]}) begin
                            n_mode = {r_mode[11:0], hexv};
                        end
                        if (hdr_cur inside {[SIZE_FIRST:SIZE_LAST]}) begin
                            n_size = {r_size[POS_W-5:0], hexv};
                        end
                        if (hdr_cur inside {[NLEN_FIRST:NLEN_LAST]}) begin
                            n_nlen = {r_nlen[POS_W-5:0], hexv};
                        end
                        if (hdr_cur == HDR_LAST) begin
                            n_hdr        = 7'd0;
                            n_prefix     = 24'd0;
                            n_tmatch     = 4'hF;
                            n_name_idx   = 4'd0;
                            n_name_start = pos1_cur;
                            if (r_nlen == '0) begin
                                do_finish = 1'b1;
                            end else begin
                                n_left  = r_nlen;
                                n_phase = PH_NAME;
                            end
                        end else begin
                            n_hdr = hdr_cur + 7'd1;
                        end
                    end
                end
                PH_NAME: begin
                    n_prefix = upd_prefix;
                    n_tmatch = upd_tmatch;
                    if (r_name_idx < NAME_IDX_MAX) begin
                        n_name_idx = r_name_idx + 4'd1;
                    end
                    n_left = r_left - POS_W'(1);
                    if (r_left == POS_W'(1)) begin
                        do_finish = 1'b1;
                    end
                end
                PH_SKIP: begin
                    n_left = r_left - POS_W'(1);
                    if (r_left == POS_W'(1)) begin
                        n_phase = PH_HEADER;
                    end
                end
                default: begin
                end
            endcase
            if (do_finish) begin
                o_produce         = 1'b1;
                o_rec.record_kind = fin_kind;
                o_rec.file_type   = ty;
                o_rec.file_size   = r_size;
                o_rec.data_offset = data_off;
                o_rec.name_offset = name_off;
                o_rec.name_size   = r_nlen;
                o_rec.file_count  = files_cur;
                n_first           = 1'b0;
                if (trailer) begin
                    n_phase = PH_DONE;
                end else begin
                    n_left  = skip_len;
                    n_phase = (skip_len != '0) ? PH_SKIP : PH_HEADER;
                    if (fin_kind == KIND_FILE) begin
                        n_files          = files_inc;
                        o_rec.file_count = files_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_pos_p1     <= POS_W'(1);
            r_phase      <= PH_HEADER;
            r_hdr        <= 7'd0;
            r_mode       <= '0;
            r_size       <= '0;
            r_nlen       <= '0;
            r_left       <= '0;
            r_prefix     <= 24'd0;
            r_tmatch     <= 4'hF;
            r_name_idx   <= 4'd0;
            r_name_start <= '0;
            r_files      <= '0;
            r_first      <= 1'b1;
        end else begin
            r_pos        <= n_pos;
            r_pos_p1     <= n_pos_p1;
            r_phase      <= n_phase;
            r_hdr        <= n_hdr;
            r_mode       <= n_mode;
            r_size       <= n_size;
            r_nlen       <= n_nlen;
            r_left       <= n_left;
            r_prefix     <= n_prefix;
            r_tmatch     <= n_tmatch;
            r_name_idx   <= n_name_idx;
            r_name_start <= n_name_start;
            r_files      <= n_files;
            r_first      <= n_first;
        end
    end

    // The size field settles dozens of beats before the entry record, so its
    // rounded copy may lag it through a register.
    always_ff @(posedge i_clk) begin
        r_size_al <= (r_size + POS_W'(3)) & ~POS_W'(3);
    end

    assign o_status.phase   = r_phase;
    assign o_status.hdr_idx = r_hdr;

endmodule

/* rtl/core/cnd_out_stage.sv */
// ----------------------------------------------------------------------------
// cnd_out_stage
// Output register for entry records; holds a record until it is taken.
// ----------------------------------------------------------------------------
module cnd_out_stage
    import cnd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_record  i_rec,
    output logic     o_free,
    cnd_rec_if.source o_rec
);

    logic    r_valid;
    t_record r_rec;

    assign o_free = !r_valid || o_rec.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_rec.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rec <= i_rec;
        end
    end

    assign o_rec.valid       = r_valid;
    assign o_rec.record_kind = r_rec.record_kind;
    assign o_rec.file_type   = r_rec.file_type;
    assign o_rec.file_size   = r_rec.file_size;
    assign o_rec.data_offset = r_rec.data_offset;
    assign o_rec.name_offset = r_rec.name_offset;
    assign o_rec.name_size   = r_rec.name_size;
    assign o_rec.file_count  = r_rec.file_count;

endmodule

/* rtl/core/cpio_newc_entry_deframer.sv */
// ----------------------------------------------------------------------------
// cpio_newc_entry_deframer
// Parses a cpio newc archive byte stream and emits one record per entry.
// ----------------------------------------------------------------------------
//  Channel   Dir  Beat contents
//  i_byte    in   data_byte, archive_start
//  o_rec     out  record_kind, file_type, file_size, data_offset,
//                 name_offset, name_size, file_count
//  i_cfg_*   in   register write: index 0 strip dot-slash, 1 strip slash
//
// One byte is accepted per cycle while no record stalls; a record reaches
// o_rec from its completing byte through the input and output registers.
// The parser state updates once per byte in a single pass of logic.
// After reset both strip options are on and the first beat can enter at once.
// A stalled record holds the parser; the input register still takes one beat.
// ----------------------------------------------------------------------------
module cpio_newc_entry_deframer
    import cnd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    cnd_byte_if.sink  i_byte,
    cnd_rec_if.source o_rec,
    input  logic      i_cfg_we,
    input  logic      i_cfg_idx,
    input  logic      i_cfg_data
);

    t_cfg    r_cfg;
    logic    in_valid;
    t_beat   in_beat;
    logic    out_free;
    logic    adv;
    logic    produce;
    t_record rec;
    t_status status;

    assign adv = in_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.strip_dot   <= 1'b1;
            r_cfg.strip_slash <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STRIP_DOT:   r_cfg.strip_dot   <= i_cfg_data;
                CFG_STRIP_SLASH: r_cfg.strip_slash <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    cnd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_adv   (adv),
        .o_valid (in_valid),
        .o_beat  (in_beat)
    );

    cnd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_beat    (in_beat),
        .i_cfg     (r_cfg),
        .o_produce (produce),
        .o_rec     (rec),
        .o_status  (status)
    );

    cnd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv && produce),
        .i_rec   (rec),
        .o_free  (out_free),
        .o_rec   (o_rec)
    );

    a_rec_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && produce) |=> o_rec.valid)
        else $error("record produced but output not valid");

    a_hdr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.phase != PH_HEADER) |-> (status.hdr_idx == 7'd0))
        else $error("header index left nonzero outside header phase");

    a_hdr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.hdr_idx <= HDR_LAST)
        else $error("header index beyond header length");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec.valid |-> (o_rec.record_kind <= KIND_LATER_BAD))
        else $error("record kind out of range");

endmodule

/* tb/cpio_newc_entry_deframer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpio_newc_entry_deframer_tb
// Feeds cpio newc archives byte by byte into the deframer, both as
// well-formed entries and as damaged, cut or noisy streams. A shadow parser
// predicts each entry record, and every record beat is checked field by field.
// ----------------------------------------------------------------------------
module cpio_newc_entry_deframer_tb;
    import cnd_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int IDLE_PCT       = 21;
    localparam int RANDOM_BYTES   = 1550;
    localparam int RANDOM_RECORDS = 48;
    localparam int SETTLE_CYCLES  = 8;
    localparam int ENTRY_WHOLE    = 1 << 30;
    localparam int HDR_BYTES      = 110;

    localparam logic [47:0] MAGIC_TXT   = "070701";
    localparam logic [79:0] TRAILER_TXT = "TRAILER!!!";

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic i_cfg_data;

    cnd_byte_if byte_ch ();
    cnd_rec_if  rec_ch ();

    cpio_newc_entry_deframer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (byte_ch),
        .o_rec      (rec_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    logic        cfg_dot;
    logic        cfg_slash;
    logic [1:0]  arc_phase;
    logic [6:0]  arc_hdr_idx;
    logic [31:0] arc_pos;
    logic [31:0] arc_mode;
    logic [31:0] arc_size;
    logic [31:0] arc_nlen;
    logic [31:0] arc_left;
    logic [23:0] arc_prefix;
    logic [3:0]  arc_tmatch;
    logic [31:0] arc_files;
    logic        arc_first;

    t_record     pending_records[$];
    int          mismatches;
    int          records_due;
    int          bytes_parsed;
    int          cycle_count;
    logic        calm;

    logic [7:0]  hdr_buf [HDR_BYTES];
    logic [7:0]  name_buf [16];
    int          name_len;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "A" && c <= "F") return c - "A" + 8'd10;
        if (c >= "a" && c <= "f") return c - "a" + 8'd10;
        return 4'd0;
    endfunction

    task automatic restart_tracking();
        arc_pos     = '0;
        arc_phase   = PH_HEADER;
        arc_hdr_idx = '0;
        arc_mode    = '0;
        arc_size    = '0;
        arc_nlen    = '0;
        arc_left    = '0;
        arc_prefix  = '0;
        arc_tmatch  = 4'hF;
        arc_files   = '0;
        arc_first   = 1'b1;
    endtask

    task automatic expect_record(input t_record r);
        pending_records.push_back(r);
        records_due++;
    endtask

    task automatic close_entry(input logic [31:0] here);
        t_record     r;
        logic [31:0] strip;
        logic [31:0] next_hdr;
        logic        is_reg;
        r = '0;
        r.file_type = arc_mode[15:12];
        strip = '0;
        if (cfg_dot && arc_nlen >= 2 && arc_prefix[7:0] == "." && arc_prefix[15:8] == "/")
            strip = 32'd2;
        if (cfg_slash && arc_nlen > strip && arc_prefix[8*strip[1:0] +: 8] == "/")
            strip = strip + 32'd1;
        r.data_offset = (here + 32'd4) & ~32'd3;
        is_reg = (r.file_type == TYPE_REG || r.file_type == TYPE_LINK);
        if (arc_tmatch[strip[1:0]] && arc_nlen >= strip + 32'd10) begin
            r.record_kind = KIND_TRAILER;
            arc_phase = PH_DONE;
        end else begin
            if (r.file_type == TYPE_DIR || (is_reg && arc_size == 0)) begin
                r.record_kind = KIND_DIR;
            end else if (is_reg) begin
                r.record_kind = KIND_FILE;
                if (arc_files != '1) arc_files = arc_files + 32'd1;
            end else begin
                r.record_kind = KIND_IGNORED;
            end
            next_hdr = (r.data_offset + arc_size + 32'd3) & ~32'd3;
            arc_left = next_hdr - (here + 32'd1);
            arc_phase = (arc_left != 0) ? PH_SKIP : PH_HEADER;
        end
        arc_first = 1'b0;
        r.file_size   = arc_size;
        r.name_offset = here + 32'd1 - arc_nlen + strip;
        r.name_size   = arc_nlen;
        r.file_count  = arc_files;
        expect_record(r);
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic st);
        logic [31:0] here;
        logic [31:0] ni;
        t_record     bad;
        int          k;
        if (st) restart_tracking();
        here = arc_pos;
        case (arc_phase)
            PH_HEADER: begin
                if (arc_hdr_idx == 0) begin
                    arc_mode = '0;
                    arc_size = '0;
                    arc_nlen = '0;
                end
                if (arc_hdr_idx < MAGIC_LEN
                        && b != MAGIC_TXT[8*(5 - int'(arc_hdr_idx)) +: 8]) begin
                    bad = '0;
                    bad.record_kind = arc_first ? KIND_FIRST_BAD : KIND_LATER_BAD;
                    bad.file_count = arc_files;
                    expect_record(bad);
                    arc_hdr_idx = '0;
                    arc_phase = PH_DONE;
                end else begin
                    if (arc_hdr_idx >= MODE_FIRST && arc_hdr_idx <= MODE_LAST)
                        arc_mode = (arc_mode << 4) + digit_value(b);
                    if (arc_hdr_idx >= SIZE_FIRST && arc_hdr_idx <= SIZE_LAST)
                        arc_size = (arc_size << 4) + digit_value(b);
                    if (arc_hdr_idx >= NLEN_FIRST && arc_hdr_idx <= NLEN_LAST)
                        arc_nlen = (arc_nlen << 4) + digit_value(b);
                    if (arc_hdr_idx == HDR_LAST) begin
                        arc_hdr_idx = '0;
                        arc_prefix = '0;
                        arc_tmatch = 4'hF;
                        if (arc_nlen == 0) begin
                            close_entry(here);
                        end else begin
                            arc_left = arc_nlen;
                            arc_phase = PH_NAME;
                        end
                    end else begin
                        arc_hdr_idx = arc_hdr_idx + 7'd1;
                    end
                end
            end
            PH_NAME: begin
                ni = arc_nlen - arc_left;
                if (ni < 3) arc_prefix[8*ni[1:0] +: 8] = arc_prefix[8*ni[1:0] +: 8] | b;
                for (k = 0; k < 4; k++) begin
                    if (ni >= k && ni - k < 10 && b != TRAILER_TXT[8*(9 - int'(ni - k)) +: 8])
                        arc_tmatch[k] = 1'b0;
                end
                if (arc_left != 0) arc_left = arc_left - 32'd1;
                if (arc_left == 0) close_entry(here);
            end
            PH_SKIP: begin
                if (arc_left != 0) arc_left = arc_left - 32'd1;
                if (arc_left == 0) arc_phase = PH_HEADER;
            end
            default: ;
        endcase
        arc_pos = here + 32'd1;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic st);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid         <= 1'b1;
        byte_ch.data_byte     <= b;
        byte_ch.archive_start <= st;
        @(posedge i_clk);
        while (byte_ch.ready !== 1'b1) @(posedge i_clk);
        if (st || arc_phase != PH_DONE) bytes_parsed++;
        parse_byte(b, st);
    endtask

    task automatic drain();
        byte_ch.valid <= 1'b0;
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_STRIP_DOT) cfg_dot = val;
        else cfg_slash = val;
    endtask

    task automatic set_strip(input logic dot, input logic slash);
        drain();
        write_reg(CFG_STRIP_DOT, dot);
        write_reg(CFG_STRIP_SLASH, slash);
    endtask

    task automatic put_hex_field(input int at, input logic [31:0] v);
        logic [3:0] n;
        logic [7:0] c;
        int         d;
        for (d = 0; d < 8; d++) begin
            n = v[31 - 4*d -: 4];
            if (n < 10) c = "0" + n;
            else c = ($urandom_range(1) ? "a" : "A") + n - 8'd10;
            if (n == 0 && $urandom_range(3) == 0) begin
                c = $urandom_range(255);
                while (c == "0" || digit_value(c) != 0) c = $urandom_range(255);
            end
            hdr_buf[at + d] = c;
        end
    endtask

    task automatic set_name(input string s);
        int i;
        name_len = s.len();
        for (i = 0; i < name_len; i++) name_buf[i] = s[i];
    endtask

    function automatic string name_variant(input int k);
        case (k)
            0: return "./TRAILER!!!";
            1: return "/TRAILER!!!";
            2: return ".//TRAILER!!!";
            3: return "./";
            4: return "/";
            5: return "TRAILER!!";
            6: return ".TRAILER!!!";
            default: return "TRAILER!!!";
        endcase
    endfunction

    task automatic send_entry(input logic [31:0] mode, input logic [31:0] fsize,
                              input logic [31:0] nsize, input int bad_at,
                              input logic first, input int cut);
        int i;
        int j;
        int sent;
        for (i = 0; i < HDR_BYTES; i++) hdr_buf[i] = $urandom_range(255);
        for (i = 0; i < 6; i++) hdr_buf[i] = MAGIC_TXT[8*(5 - i) +: 8];
        put_hex_field(MODE_FIRST, mode);
        put_hex_field(SIZE_FIRST, fsize);
        put_hex_field(NLEN_FIRST, nsize);
        if (bad_at >= 0) hdr_buf[bad_at] = hdr_buf[bad_at] ^ 8'($urandom_range(1, 255));
        sent = 0;
        for (i = 0; i < HDR_BYTES && sent < cut; i++) begin
            send_byte(hdr_buf[i], first && i == 0);
            sent++;
            if (arc_phase == PH_DONE) return;
        end
        j = 0;
        while (arc_phase == PH_NAME && sent < cut) begin
            send_byte(j < name_len ? name_buf[j] : 8'h00, 1'b0);
            j++;
            sent++;
        end
        while (arc_phase == PH_SKIP && sent < cut) begin
            send_byte($urandom_range(255), 1'b0);
            sent++;
        end
    endtask

    task automatic named_entry(input string nm, input logic [31:0] mode,
                               input logic [31:0] fsize, input logic first);
        set_name(nm);
        send_entry(mode, fsize, nm.len() + 1, -1, first, ENTRY_WHOLE);
    endtask

    task automatic send_random_entry(input logic first, input int bad_at, input int cut);
        logic [31:0] mode;
        logic [31:0] fsize;
        logic [31:0] nsize;
        int          p;
        int          i;
        mode = $urandom;
        p = $urandom_range(9);
        mode[15:12] = (p < 3) ? TYPE_REG : (p < 5) ? TYPE_DIR : (p < 7) ? TYPE_LINK
                    : 4'($urandom);
        p = $urandom_range(99);
        if (p < 30) fsize = '0;
        else if (p < 85) fsize = $urandom_range(1, 40);
        else if (p < 93) fsize = $urandom_range(41, 300);
        else fsize = 32'hFFFFFFFF - $urandom_range(2);
        p = $urandom_range(9);
        if (p < 4) begin
            set_name(name_variant($urandom_range(7)));
        end else begin
            name_len = $urandom_range(0, 12);
            for (i = 0; i < name_len; i++)
                name_buf[i] = (p < 8) ? $urandom_range(33, 126) : $urandom_range(255);
            if (name_len >= 2 && $urandom_range(2) == 0) begin
                name_buf[0] = ".";
                name_buf[1] = "/";
            end else if (name_len >= 1 && $urandom_range(1) == 0) begin
                name_buf[0] = "/";
            end
        end
        p = $urandom_range(19);
        if (p == 0) nsize = '0;
        else if (p == 1) nsize = name_len;
        else if (p == 2) nsize = name_len + 3;
        else nsize = name_len + 1;
        send_entry(mode, fsize, nsize, bad_at, first, cut);
    endtask

    task automatic test_bad_magic();
        set_name("x");
        send_entry(32'h000081A4, 32'd0, 32'd2, 0, 1'b1, ENTRY_WHOLE);
        send_entry(32'h000081A4, 32'd0, 32'd2, 5, 1'b1, ENTRY_WHOLE);
        named_entry("d", 32'h000041ED, 32'd0, 1'b1);
        set_name("f");
        send_entry(32'h000081A4, 32'd4, 32'd2, 3, 1'b0, ENTRY_WHOLE);
    endtask

    task automatic test_entry_kinds();
        named_entry("./usr", 32'h000041ED, 32'd0, 1'b1);
        named_entry("./usr/a.txt", 32'h000081A4, 32'd5, 1'b0);
        named_entry("lnk", 32'h0000A1FF, 32'd0, 1'b0);
        named_entry("./dev/tty", 32'h000021B6, 32'd3, 1'b0);
        named_entry("w", 32'h000081A4, 32'hFFFFFFFF, 1'b0);
        set_name("");
        send_entry(32'h000081A4, 32'd7, 32'd0, -1, 1'b0, ENTRY_WHOLE);
        named_entry("/abs", 32'hFFFFA000, 32'd1, 1'b0);
        named_entry("./TRAILER!!!", 32'd0, 32'd0, 1'b0);
    endtask

    task automatic test_strip_options();
        int c;
        int k;
        for (c = 0; c < 4; c++) begin
            set_strip(c[1], c[0]);
            for (k = 0; k < 6; k++) named_entry(name_variant(k), 32'h000081A4, 32'd1, 1'b1);
        end
        set_name("TRAILER!!!");
        send_entry(32'd0, 32'd0, 32'd10, -1, 1'b1, ENTRY_WHOLE);
    endtask

    task automatic test_restart();
        named_entry("a", 32'h000081A4, 32'd9, 1'b1);
        named_entry("b", 32'h000081A4, 32'd2, 1'b0);
        set_name("cut");
        send_entry(32'h000081A4, 32'd20, 32'd4, -1, 1'b0, 60);
        set_name("c");
        send_entry(32'h000081A4, 32'd6, 32'd2, -1, 1'b1, HDR_BYTES + 3);
        named_entry("d", 32'h000081A4, 32'd1, 1'b1);
        set_name("e");
        send_entry(32'h000081A4, 32'd1, 32'd12, -1, 1'b1, HDR_BYTES + 5);
        named_entry("TRAILER!!!", 32'd0, 32'd0, 1'b1);
        named_entry("z", 32'h000081A4, 32'd0, 1'b0);
        named_entry("f", 32'h000081A4, 32'd3, 1'b1);
    endtask

    task automatic test_random_archives();
        int start_bytes;
        int start_recs;
        int archive_no;
        int n_entries;
        int pick;
        int k;
        start_bytes = bytes_parsed;
        start_recs  = records_due;
        archive_no  = 0;
        while (bytes_parsed - start_bytes < RANDOM_BYTES
                || records_due - start_recs < RANDOM_RECORDS) begin
            calm = (archive_no >= 8 && archive_no < 16);
            if (archive_no % 6 == 5) begin
                if ($urandom_range(1)) set_strip($urandom_range(1), $urandom_range(1));
                else drain();
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                n_entries = $urandom_range(1, 4);
                for (k = 0; k < n_entries; k++) begin
                    if (k > 0 && arc_phase == PH_DONE) break;
                    send_random_entry(k == 0, -1, ENTRY_WHOLE);
                end
                if (arc_phase != PH_DONE && $urandom_range(99) < 70)
                    named_entry("TRAILER!!!", $urandom, 32'd0, 1'b0);
            end else if (pick < 82) begin
                n_entries = $urandom_range(0, 2);
                for (k = 0; k < n_entries; k++) send_random_entry(k == 0, -1, ENTRY_WHOLE);
                send_random_entry(n_entries == 0, $urandom_range(0, 5), ENTRY_WHOLE);
            end else if (pick < 92) begin
                send_random_entry(1'b1, -1, $urandom_range(1, 140));
            end else begin
                n_entries = $urandom_range(4, 24);
                for (k = 0; k < n_entries; k++) send_byte($urandom_range(255), k == 0);
            end
            archive_no++;
        end
        calm = 1'b0;
    endtask

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    task automatic check_record();
        t_record want;
        if (pending_records.size() == 0) begin
            $display("%0t: record beat with nothing pending, expected none, got kind %0d",
                     $time, rec_ch.record_kind);
            mismatches++;
        end else begin
            want = pending_records.pop_front();
            compare_field("record_kind", want.record_kind, rec_ch.record_kind);
            compare_field("file_type", want.file_type, rec_ch.file_type);
            compare_field("file_size", want.file_size, rec_ch.file_size);
            compare_field("data_offset", want.data_offset, rec_ch.data_offset);
            compare_field("name_offset", want.name_offset, rec_ch.name_offset);
            compare_field("name_size", want.name_size, rec_ch.name_size);
            compare_field("file_count", want.file_count, rec_ch.file_count);
        end
    endtask

    initial begin
        rec_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rec_ch.valid === 1'b1 && rec_ch.ready === 1'b1) check_record();
            rec_ch.ready <= i_rst_n && (calm || $urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_idx             <= 1'b0;
        i_cfg_data            <= 1'b0;
        byte_ch.valid         <= 1'b0;
        byte_ch.data_byte     <= 8'h00;
        byte_ch.archive_start <= 1'b0;
        mismatches   = 0;
        records_due  = 0;
        bytes_parsed = 0;
        calm         = 1'b0;
        cfg_dot      = 1'b1;
        cfg_slash    = 1'b1;
        restart_tracking();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_bad_magic();
        test_entry_kinds();
        test_strip_options();
        test_restart();
        test_random_archives();
        drain();
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/cnd_pkg.sv
rtl/core/cnd_byte_if.sv
rtl/core/cnd_rec_if.sv
rtl/core/cnd_in_stage.sv
rtl/core/cnd_parser.sv
rtl/core/cnd_out_stage.sv
rtl/core/cpio_newc_entry_deframer.sv
tb/cpio_newc_entry_deframer_tb.sv
